// File: rtl/obc_pkg.sv
// Shared types, constants and helpers for the oriented box corner block.
package obc_pkg;

	localparam int COORD_BITS  = 24;
	localparam int ANGLE_BITS  = 16;
	localparam int EXT_BITS    = 16;
	localparam int TRIG_STAGES = 16;
	localparam int CW          = 34;                // cordic datapath, Q2.30 plus headroom
	localparam int PW          = CW + EXT_BITS + 1; // trig * extent product
	localparam int OW          = PW + 1;            // sum of two products
	localparam int DW          = OW - 31;           // rounded half offset
	localparam int SW          = COORD_BITS + 2;    // centre plus offset

	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_z;
		logic        [ANGLE_BITS-1:0] heading;
		logic        [EXT_BITS-1:0]   box_length;
		logic        [EXT_BITS-1:0]   box_width;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] corner0_x;
		logic signed [COORD_BITS-1:0] corner0_y;
		logic signed [COORD_BITS-1:0] corner1_x;
		logic signed [COORD_BITS-1:0] corner1_y;
		logic signed [COORD_BITS-1:0] corner2_x;
		logic signed [COORD_BITS-1:0] corner2_y;
		logic signed [COORD_BITS-1:0] corner3_x;
		logic signed [COORD_BITS-1:0] corner3_y;
		logic signed [COORD_BITS-1:0] corner_height;
	} out_word_t;

	// sin/cos plus the geometry handed from front to back
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] cz;
		logic        [EXT_BITS-1:0]   len;
		logic        [EXT_BITS-1:0]   wid;
		logic signed [CW-1:0]         c;
		logic signed [CW-1:0]         s;
	} mid_word_t;

	// arctangent of 2^-i in 32-bit full-circle units
	function automatic logic signed [CW-1:0] atan_q32(input logic [4:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clamp to the signed coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v[SW-1:COORD_BITS-1] == '0 || v[SW-1:COORD_BITS-1] == '1) begin
			r = v[COORD_BITS-1:0];
		end else if (v[SW-1]) begin
			r = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: rtl/obc_front.sv
// Front end: quadrant split and pipelined CORDIC sine/cosine.
module obc_front import obc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_push,
	input  in_word_t  in_word,
	output logic      in_ready,
	output logic      mid_push,
	output mid_word_t mid_word,
	input  logic      mid_full
);

	localparam int N = TRIG_STAGES;

	logic                  v_q [0:N];
	in_word_t              obj_s [0:N];
	logic [1:0]            q_s [0:N];
	logic signed [CW-1:0]  x_s [0:N];
	logic signed [CW-1:0]  y_s [0:N];
	logic signed [CW-1:0]  z_s [0:N];

	logic                  adv;
	logic [31:0]           ang;
	logic [31:0]           qsum;
	logic [1:0]            quad;
	logic [31:0]           resid;
	logic signed [CW-1:0]  c_rot;
	logic signed [CW-1:0]  s_rot;

	assign adv      = !(v_q[N] && mid_full);
	assign in_ready = adv;

	assign ang   = {in_word.heading, {(32-ANGLE_BITS){1'b0}}};
	assign qsum  = ang + 32'h2000_0000;
	assign quad  = qsum[31:30];
	assign resid = ang - {quad, 30'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_push;
			for (int i = 0; i < N; i++) v_q[i+1] <= v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			obj_s[0] <= in_word;
			q_s[0]   <= quad;
			x_s[0]   <= GAIN_Q30;
			y_s[0]   <= '0;
			z_s[0]   <= $signed({{(CW-32){resid[31]}}, resid});
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (adv) begin
				obj_s[i+1] <= obj_s[i];
				q_s[i+1]   <= q_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - atan_q32(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + atan_q32(5'(i));
				end
			end
		end
	end

	// quarter-turn correction
	always_comb begin
		case (q_s[N])
			2'd1: begin c_rot = -y_s[N]; s_rot =  x_s[N]; end
			2'd2: begin c_rot = -x_s[N]; s_rot = -y_s[N]; end
			2'd3: begin c_rot =  y_s[N]; s_rot = -x_s[N]; end
			default: begin c_rot = x_s[N]; s_rot = y_s[N]; end
		endcase
	end

	assign mid_push     = v_q[N] && adv;
	assign mid_word.cx  = obj_s[N].center_x;
	assign mid_word.cy  = obj_s[N].center_y;
	assign mid_word.cz  = obj_s[N].center_z;
	assign mid_word.len = obj_s[N].box_length;
	assign mid_word.wid = obj_s[N].box_width;
	assign mid_word.c   = c_rot;
	assign mid_word.s   = s_rot;

endmodule

// File: rtl/obc_queue.sv
// Four-entry queue between front and back.
module obc_queue import obc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mid_word_t wdata,
	output logic      full,
	input  logic      pop,
	output mid_word_t rdata,
	output logic      empty
);

	mid_word_t  mem_q [0:3];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop)  rd_q <= rd_q + 2'd1;
			if (push && !pop)      cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

// File: rtl/obc_back.sv
// Back end: offset products, rounding, corner sums and result buffer.
module obc_back import obc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mid_empty,
	input  mid_word_t mid_word,
	output logic      mid_pop,
	output logic      out_empty,
	input  logic      out_pop,
	output out_word_t out_word
);

	localparam logic signed [OW-1:0] RND = OW'(1) <<< 30;

	logic v1_q, v2_q, v3_q;
	logic adv;

	logic signed [PW-1:0] pcl_s1, psl_s1, pcw_s1, psw_s1;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1, cz_s1;

	logic signed [DW-1:0] dx_s2 [0:3];
	logic signed [DW-1:0] dy_s2 [0:3];
	logic signed [COORD_BITS-1:0] cx_s2, cy_s2, cz_s2;

	logic signed [DW-1:0] dx_c [0:3];
	logic signed [DW-1:0] dy_c [0:3];
	out_word_t res_s3;
	out_word_t res_c;

	out_word_t  obuf_q [0:1];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic       ofull, opush;

	logic signed [EXT_BITS:0] len_sx, wid_sx;

	assign ofull   = (ocnt_q == 2'd2);
	assign adv     = !(v3_q && ofull);
	assign mid_pop = adv && !mid_empty;
	assign opush   = v3_q && adv;

	assign len_sx = $signed({1'b0, mid_word.len});
	assign wid_sx = $signed({1'b0, mid_word.wid});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= mid_pop;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	// corner k: length sign from k[1], width sign positive for k = 1, 2
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic signed [OW-1:0] tx, ty, a_cl, a_sl, a_cw, a_sw;
			a_cl = OW'(pcl_s1);
			a_sl = OW'(psl_s1);
			a_cw = OW'(pcw_s1);
			a_sw = OW'(psw_s1);
			if (k >= 2) begin
				tx = a_cl;
				ty = a_sl;
			end else begin
				tx = -a_cl;
				ty = -a_sl;
			end
			if (k == 1 || k == 2) begin
				tx = tx - a_sw;
				ty = ty + a_cw;
			end else begin
				tx = tx + a_sw;
				ty = ty - a_cw;
			end
			tx = tx + RND;
			ty = ty + RND;
			dx_c[k] = tx[OW-1:31];
			dy_c[k] = ty[OW-1:31];
		end
	end

	always_comb begin
		res_c.corner0_x     = sat_coord(SW'(cx_s2) + SW'(dx_s2[0]));
		res_c.corner0_y     = sat_coord(SW'(cy_s2) + SW'(dy_s2[0]));
		res_c.corner1_x     = sat_coord(SW'(cx_s2) + SW'(dx_s2[1]));
		res_c.corner1_y     = sat_coord(SW'(cy_s2) + SW'(dy_s2[1]));
		res_c.corner2_x     = sat_coord(SW'(cx_s2) + SW'(dx_s2[2]));
		res_c.corner2_y     = sat_coord(SW'(cy_s2) + SW'(dy_s2[2]));
		res_c.corner3_x     = sat_coord(SW'(cx_s2) + SW'(dx_s2[3]));
		res_c.corner3_y     = sat_coord(SW'(cy_s2) + SW'(dy_s2[3]));
		res_c.corner_height = cz_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcl_s1 <= mid_word.c * len_sx;
			psl_s1 <= mid_word.s * len_sx;
			pcw_s1 <= mid_word.c * wid_sx;
			psw_s1 <= mid_word.s * wid_sx;
			cx_s1  <= mid_word.cx;
			cy_s1  <= mid_word.cy;
			cz_s1  <= mid_word.cz;
			for (int k = 0; k < 4; k++) begin
				dx_s2[k] <= dx_c[k];
				dy_s2[k] <= dy_c[k];
			end
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			cz_s2  <= cz_s1;
			res_s3 <= res_c;
		end
		if (opush) obuf_q[owr_q] <= res_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (opush)   owr_q <= !owr_q;
			if (out_pop && !out_empty) ord_q <= !ord_q;
			if (opush && !(out_pop && !out_empty))      ocnt_q <= ocnt_q + 2'd1;
			else if (!opush && out_pop && !out_empty)   ocnt_q <= ocnt_q - 2'd1;
		end
	end

	assign out_empty = (ocnt_q == 2'd0);
	assign out_word  = obuf_q[ord_q];

endmodule

// File: rtl/oriented_box_corners_top.sv
// Top level of the oriented box corner block.
//
//  channel | ports               | handshake
//  --------+---------------------+-----------------------------------------
//  input   | in_word, push, full | word taken when push && !full
//  result  | out_word, empty,pop | word taken when pop && !empty
//
// One object per cycle sustained while pop keeps up. From accept to
// result visible: quadrant register, 16 CORDIC stages, the four-entry
// queue, three back stages (products, rounding, sum and clamp), buffer.
// Reset (arst_n low) empties all pipelines and queues; the block keeps
// no state between objects. A stalled result side fills the output
// buffer, then the back stages, then the queue; only then does full rise.
module oriented_box_corners_top import obc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_word_t  in_word,
	output logic      full,
	output logic      empty,
	input  logic      pop,
	output out_word_t out_word
);

	logic      in_ready;
	logic      mid_push, mid_full, mid_pop, mid_empty;
	mid_word_t mid_wdata, mid_rdata;

	assign full = !in_ready;

	// front: angle reduction and sine/cosine
	obc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_push  (push),
		.in_word  (in_word),
		.in_ready (in_ready),
		.mid_push (mid_push),
		.mid_word (mid_wdata),
		.mid_full (mid_full)
	);

	// decoupling queue
	obc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	// back: rotate extents, add to centre, clamp
	obc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_word  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_empty (empty),
		.out_pop   (pop),
		.out_word  (out_word)
	);

	// queue is never overrun nor read empty
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full) else $error("queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty) else $error("queue underrun");
	// input side stalls only when the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_full) else $error("stall without full queue");

endmodule

// File: tb/obc_checker.sv
// Checker for the oriented box corner block: predicts corners and compares results.
module obc_checker import obc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_word_t  in_word,
	input  logic      pop,
	input  logic      empty,
	input  out_word_t out_word,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint GAIN = 652032874;

	out_word_t corners_due[$];

	function automatic longint atan_step(input int i);
		longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	function automatic logic signed [COORD_BITS-1:0] clamp(input longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi[COORD_BITS-1:0];
		if (v < lo) return lo[COORD_BITS-1:0];
		return v[COORD_BITS-1:0];
	endfunction

	function automatic out_word_t box_corners(input in_word_t w);
		out_word_t r;
		logic [31:0] a, ru;
		logic [1:0] q;
		longint x, y, z, xs, ys, t, lx, ly, dx, dy, cx, cy;
		int lsg[4] = '{-1, -1, 1, 1};
		int wsg[4] = '{-1, 1, 1, -1};
		logic signed [COORD_BITS-1:0] px[4], py[4];
		a = {w.heading, {(32 - ANGLE_BITS){1'b0}}};
		q = 2'((a + 32'h2000_0000) >> 30);
		ru = a - ({30'd0, q} << 30);
		z = longint'($signed(ru));
		x = GAIN;
		y = 0;
		for (int i = 0; i < TRIG_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_step(i);
			end else begin
				x = x + ys; y = y - xs; z = z + atan_step(i);
			end
		end
		case (q)
			2'd1: begin t = x; x = -y; y = t; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		cx = longint'(w.center_x);
		cy = longint'(w.center_y);
		for (int k = 0; k < 4; k++) begin
			lx = lsg[k] * longint'(w.box_length);
			ly = wsg[k] * longint'(w.box_width);
			dx = (x * lx - y * ly + (longint'(1) <<< 30)) >>> 31;
			dy = (y * lx + x * ly + (longint'(1) <<< 30)) >>> 31;
			px[k] = clamp(cx + dx);
			py[k] = clamp(cy + dy);
		end
		r.corner0_x = px[0]; r.corner0_y = py[0];
		r.corner1_x = px[1]; r.corner1_y = py[1];
		r.corner2_x = px[2]; r.corner2_y = py[2];
		r.corner3_x = px[3]; r.corner3_y = py[3];
		r.corner_height = w.center_z;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = corners_due.size();

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n) begin
			if (push && !full) corners_due.push_back(box_corners(in_word));
			if (pop && !empty) begin
				if (corners_due.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					e = corners_due.pop_front();
					if (out_word.corner0_x !== e.corner0_x) report("corner0_x", out_word.corner0_x, e.corner0_x);
					if (out_word.corner0_y !== e.corner0_y) report("corner0_y", out_word.corner0_y, e.corner0_y);
					if (out_word.corner1_x !== e.corner1_x) report("corner1_x", out_word.corner1_x, e.corner1_x);
					if (out_word.corner1_y !== e.corner1_y) report("corner1_y", out_word.corner1_y, e.corner1_y);
					if (out_word.corner2_x !== e.corner2_x) report("corner2_x", out_word.corner2_x, e.corner2_x);
					if (out_word.corner2_y !== e.corner2_y) report("corner2_y", out_word.corner2_y, e.corner2_y);
					if (out_word.corner3_x !== e.corner3_x) report("corner3_x", out_word.corner3_x, e.corner3_x);
					if (out_word.corner3_y !== e.corner3_y) report("corner3_y", out_word.corner3_y, e.corner3_y);
					if (out_word.corner_height !== e.corner_height)
						report("corner_height", out_word.corner_height, e.corner_height);
				end
			end
		end
	end
endmodule

// File: tb/tb_oriented_box_corners_top.sv
// Testbench top for the oriented box corner block: stimulus, flow control, verdict.
module tb_oriented_box_corners_top;
	import obc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 500;
	localparam int LATENCY      = 21;
	localparam int CYCLE_LIMIT  = 200000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	logic      full, empty;
	in_word_t  in_word = '0;
	out_word_t out_word;
	int        fail_count, pending;
	int        cycles = 0;

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	oriented_box_corners_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .in_word(in_word), .full(full),
		.empty(empty), .pop(pop), .out_word(out_word)
	);

	obc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.pop(pop), .empty(empty), .out_word(out_word),
		.fail_count(fail_count), .pending(pending)
	);

	// Hand one word to the block: set it up on the falling edge, hold it
	// until a rising edge sees push && !full, then drop push.
	task automatic send_word(input in_word_t w);
		in_word <= w;
		push    <= 1'b1;
		do @(posedge clk); while (full);
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Back-to-back burst variant: keep push high across words so the block
	// sees a sustained one-word-per-cycle stream whenever full stays low.
	task automatic send_burst(input int n);
		in_word_t w;
		for (int i = 0; i < n; i++) begin
			w = random_object();
			in_word <= w;
			push    <= 1'b1;
			do @(posedge clk); while (full);
			@(negedge clk);
		end
		push <= 1'b0;
	endtask

	// Mostly moderate centres, extents moderate only one time in three; the
	// full-range centres and extents that remain drive the clamp.
	function automatic in_word_t random_object();
		in_word_t w;
		w = in_word_t'({$urandom, $urandom, $urandom, 24'($urandom)});
		if ($urandom_range(0, 3) != 0) begin
			w.center_x = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
			w.center_y = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
		end
		if ($urandom_range(0, 2) == 0) w.box_length = 16'($urandom_range(0, 2000));
		if ($urandom_range(0, 2) == 0) w.box_width  = 16'($urandom_range(0, 2000));
		return w;
	endfunction

	function automatic in_word_t obj(input logic signed [23:0] x, y, z,
		input logic [15:0] hd, ln, wd);
		in_word_t w;
		w.center_x = x; w.center_y = y; w.center_z = z;
		w.heading = hd; w.box_length = ln; w.box_width = wd;
		return w;
	endfunction

	// Receiver: stalls on a slowly varying duty pattern, with stall-free spans.
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (phase[9:8] == 2'd0) pop <= 1'b1;
			else if (phase[9:8] == 2'd1) pop <= ($urandom_range(0, 3) != 0);
			else if (phase[9:8] == 2'd2) pop <= ($urandom_range(0, 3) == 0);
			else pop <= (phase[2:0] != 3'd0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int sent;
		int n;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes of every field, the four quadrant boundaries,
		// degenerate boxes, and centres that push corners past the clamp.
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'h0000, 16'd0, 16'd0));
		send_word(obj(24'sd100, -24'sd100, 24'sd5, 16'h0000, 16'd512, 16'd256));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'h4000, 16'd512, 16'd256));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'h8000, 16'd512, 16'd256));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'hC000, 16'd512, 16'd256));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'h2000, 16'd1000, 16'd1000));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'h1FFF, 16'd1000, 16'd0));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'hE000, 16'd0, 16'd1000));
		send_word(obj(24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(obj(24'sd8388607, 24'sd8388607, 24'sd8388607, 16'h1234,
			16'hFFFF, 16'hFFFF));
		send_word(obj(-24'sd8388608, -24'sd8388608, -24'sd8388608, 16'h9ABC,
			16'hFFFF, 16'hFFFF));
		send_word(obj(24'sd8388607, -24'sd8388608, 24'sd0, 16'h6000,
			16'h8000, 16'h0001));
		send_word(obj(-24'sd8388608, 24'sd8388607, -24'sd1, 16'hA000,
			16'h0001, 16'h8000));
		send_word(obj(24'sd8388000, 24'sd8388000, 24'sd0, 16'h0000, 16'd0, 16'd0));
		send_word(obj(24'sd8380000, -24'sd8380000, 24'sd1, 16'h0001, 16'h4000, 16'h4000));
		send_word(obj(24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555, 16'hAAAA, 16'h5555));
		send_word(obj(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA, 16'h5555, 16'hAAAA));

		// Pause until the pipeline has fully drained.
		while (pending != 0) @(negedge clk);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			n = $urandom_range(1, 24);
			if (n > RANDOM_WORDS - sent) n = RANDOM_WORDS - sent;
			send_burst(n);
			sent += n;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			if (sent > 250 && sent <= 250 + n)
				while (pending != 0) @(negedge clk);
		end

		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
